@@ rtl/u8sv_pkg.sv @@
// u8sv_pkg: byte classes, queue item type and code point limits for the
// UTF-8 stream validator. No dependencies.
package u8sv_pkg;

    typedef enum logic [2:0] {
        BC_ASCII,
        BC_LEAD2,
        BC_LEAD3,
        BC_LEAD4,
        BC_INVALID,
        BC_CONT
    } t_byte_class;

    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  data;
        logic        last;
    } t_item;

    localparam int unsigned ACC_W = 21;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THR  = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    localparam logic [ACC_W-1:0]  MIN_THREE  = 21'h000800;
    localparam logic [ACC_W-1:0]  MIN_FOUR   = 21'h010000;
    localparam logic [ACC_W-1:0]  MAX_CODE   = 21'h10FFFF;
    localparam logic [ACC_W-12:0] SURR_HIGH  = 10'h01B;

endpackage

@@ rtl/u8sv_front.sv @@
// u8sv_front: input handshake and stateless byte classification.
// Depends on u8sv_pkg; feeds the item queue.
module u8sv_front (
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic            i_q_full,
    output logic            o_push,
    output u8sv_pkg::t_item o_item
);

    u8sv_pkg::t_byte_class cls;

    always_comb begin
        priority if (i_data_byte <= u8sv_pkg::ASCII_MAX) begin
            cls = u8sv_pkg::BC_ASCII;
        end else if ((i_data_byte & u8sv_pkg::CONT_MASK) == u8sv_pkg::CONT_TAG) begin
            cls = u8sv_pkg::BC_CONT;
        end else if (i_data_byte >= u8sv_pkg::LEAD2_MIN &&
                     i_data_byte <= u8sv_pkg::LEAD2_MAX) begin
            cls = u8sv_pkg::BC_LEAD2;
        end else if (i_data_byte >= u8sv_pkg::LEAD3_MIN &&
                     i_data_byte <= u8sv_pkg::LEAD3_MAX) begin
            cls = u8sv_pkg::BC_LEAD3;
        end else if (i_data_byte >= u8sv_pkg::LEAD4_MIN &&
                     i_data_byte <= u8sv_pkg::LEAD4_MAX) begin
            cls = u8sv_pkg::BC_LEAD4;
        end else begin
            cls = u8sv_pkg::BC_INVALID;
        end
    end

    assign o_stall     = i_q_full;
    assign o_push      = i_valid & ~i_q_full;
    assign o_item.cls  = cls;
    assign o_item.data = i_data_byte;
    assign o_item.last = i_last_byte;

endmodule

@@ rtl/u8sv_queue.sv @@
// u8sv_queue: small FIFO of classified items between front and back.
// Depends on u8sv_pkg.
module u8sv_queue #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8sv_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output u8sv_pkg::t_item o_item
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    u8sv_pkg::t_item  r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full   = (r_count == CNT_FULL);
    assign o_nempty = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];

endmodule

@@ rtl/u8sv_back.sv @@
// u8sv_back: sequence tracking, code point checks and the verdict register.
// Depends on u8sv_pkg; drains the item queue.
module u8sv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_nempty,
    input  u8sv_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_valid_res
);

    localparam int unsigned AW = u8sv_pkg::ACC_W;

    logic          r_failed, n_failed;
    logic [1:0]    r_left, n_left;
    logic [1:0]    r_seq, n_seq;
    logic [AW-1:0] r_acc, n_acc;
    logic          r_bad, n_bad;
    logic          r_out_valid, n_out_valid;
    logic          r_out_res, n_out_res;
    logic          out_free;
    logic          bad_seq;
    logic [AW-1:0] acc_shift;

    assign out_free  = ~r_out_valid | ~i_stall;
    assign o_pop     = i_q_nempty & (~i_item.last | out_free);
    assign acc_shift = {r_acc[AW-7:0], i_item.data[5:0]};

    always_comb begin
        unique case (r_seq)
            u8sv_pkg::SEQ_THR: begin
                bad_seq = (acc_shift < u8sv_pkg::MIN_THREE) ||
                          (acc_shift[AW-1:11] == u8sv_pkg::SURR_HIGH);
            end
            u8sv_pkg::SEQ_FOUR: begin
                bad_seq = (acc_shift < u8sv_pkg::MIN_FOUR) ||
                          (acc_shift > u8sv_pkg::MAX_CODE);
            end
            default: begin
                bad_seq = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_failed    = r_failed;
        n_left      = r_left;
        n_seq       = r_seq;
        n_acc       = r_acc;
        n_bad       = r_bad;
        n_out_valid = r_out_valid & i_stall;
        n_out_res   = r_out_res;
        if (o_pop) begin
            if (!r_failed) begin
                if (r_left == 2'd0) begin
                    unique case (i_item.cls)
                        u8sv_pkg::BC_LEAD2: begin
                            n_seq  = u8sv_pkg::SEQ_TWO;
                            n_left = u8sv_pkg::SEQ_TWO;
                            n_acc  = AW'(i_item.data[4:0]);
                            n_bad  = 1'b0;
                        end
                        u8sv_pkg::BC_LEAD3: begin
                            n_seq  = u8sv_pkg::SEQ_THR;
                            n_left = u8sv_pkg::SEQ_THR;
                            n_acc  = AW'(i_item.data[3:0]);
                            n_bad  = 1'b0;
                        end
                        u8sv_pkg::BC_LEAD4: begin
                            n_seq  = u8sv_pkg::SEQ_FOUR;
                            n_left = u8sv_pkg::SEQ_FOUR;
                            n_acc  = AW'(i_item.data[2:0]);
                            n_bad  = 1'b0;
                        end
                        u8sv_pkg::BC_ASCII: begin
                            n_failed = 1'b0;
                        end
                        default: begin
                            n_failed = 1'b1;
                        end
                    endcase
                end else begin
                    n_acc  = acc_shift;
                    n_left = r_left - 1'b1;
                    n_bad  = r_bad | (i_item.cls != u8sv_pkg::BC_CONT);
                    if (r_left == 2'd1) begin
                        n_failed = n_bad | bad_seq;
                        n_bad    = 1'b0;
                    end
                end
            end
            if (i_item.last) begin
                n_out_valid = 1'b1;
                n_out_res   = ~n_failed;
                n_failed    = 1'b0;
                n_left      = 2'd0;
                n_seq       = u8sv_pkg::SEQ_NONE;
                n_acc       = '0;
                n_bad       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed    <= 1'b0;
            r_left      <= 2'd0;
            r_seq       <= u8sv_pkg::SEQ_NONE;
            r_acc       <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_failed    <= n_failed;
            r_left      <= n_left;
            r_seq       <= n_seq;
            r_acc       <= n_acc;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;

endmodule

@@ rtl/utf8_stream_validator.sv @@
// utf8_stream_validator: takes one byte per transfer; a verdict follows the last byte.
// The verdict is registered: the last byte is written into the queue, and the back end
// loads the verdict register when it pops that byte from the queue head.
// Throughput: one byte per cycle when not stalled, set by the back end's sequence update.
// Reset (i_rst_n, synchronous) empties the queue, clears sequence state and verdict valid.
// Depends on u8sv_pkg, u8sv_front, u8sv_queue and u8sv_back.
module utf8_stream_validator #(
    parameter int unsigned P_QDEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_valid_res
);

    u8sv_pkg::t_item in_item;
    u8sv_pkg::t_item head_item;
    logic            push;
    logic            q_full;
    logic            pop;
    logic            q_nempty;

    u8sv_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (in_item)
    );

    u8sv_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (in_item),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_item   (head_item)
    );

    u8sv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_nempty  (q_nempty),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res)
    );

endmodule

@@ tb/sv/tb_utf8_stream_validator.sv @@
// Self-checking testbench for utf8_stream_validator: byte strings, directed and random,
// go in over valid/stall and each verdict is compared against an in-bench UTF-8 predictor.
// Depends on u8sv_pkg and the utf8_stream_validator RTL.
module tb_utf8_stream_validator;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned AW           = u8sv_pkg::ACC_W;

    class verdict_tracker;
        bit            failed;
        logic [1:0]    bytes_left;
        logic [1:0]    seq_len;
        logic [AW-1:0] code_acc;
        bit            bad_cont;
        bit            expected_verdicts[$];
        int unsigned   n_bytes;
        int unsigned   n_verdicts;
        int unsigned   n_accepted;
        int unsigned   errors;

        function void clear_string();
            failed     = 1'b0;
            bytes_left = 2'd0;
            seq_len    = u8sv_pkg::SEQ_NONE;
            code_acc   = '0;
            bad_cont   = 1'b0;
        endfunction

        function new();
            clear_string();
        endfunction

        function void close_sequence();
            if (bad_cont) begin
                failed = 1'b1;
            end else if (seq_len == u8sv_pkg::SEQ_THR) begin
                if (code_acc < u8sv_pkg::MIN_THREE ||
                    code_acc[AW-1:11] == u8sv_pkg::SURR_HIGH) failed = 1'b1;
            end else if (seq_len == u8sv_pkg::SEQ_FOUR) begin
                if (code_acc < u8sv_pkg::MIN_FOUR ||
                    code_acc > u8sv_pkg::MAX_CODE) failed = 1'b1;
            end
            bad_cont = 1'b0;
        endfunction

        function void take_transfer(logic [7:0] b, bit lst);
            n_bytes++;
            if (!failed) begin
                if (bytes_left == 2'd0) begin
                    if (b <= u8sv_pkg::ASCII_MAX) begin
                    end else if (b >= u8sv_pkg::LEAD2_MIN && b <= u8sv_pkg::LEAD2_MAX) begin
                        seq_len  = u8sv_pkg::SEQ_TWO;
                        code_acc = AW'(b[4:0]);
                    end else if (b >= u8sv_pkg::LEAD3_MIN && b <= u8sv_pkg::LEAD3_MAX) begin
                        seq_len  = u8sv_pkg::SEQ_THR;
                        code_acc = AW'(b[3:0]);
                    end else if (b >= u8sv_pkg::LEAD4_MIN && b <= u8sv_pkg::LEAD4_MAX) begin
                        seq_len  = u8sv_pkg::SEQ_FOUR;
                        code_acc = AW'(b[2:0]);
                    end else begin
                        failed = 1'b1;
                    end
                    if (!failed && b > u8sv_pkg::ASCII_MAX) begin
                        bytes_left = seq_len;
                        bad_cont   = 1'b0;
                    end
                end else begin
                    if ((b & u8sv_pkg::CONT_MASK) != u8sv_pkg::CONT_TAG) bad_cont = 1'b1;
                    code_acc   = {code_acc[AW-7:0], b[5:0]};
                    bytes_left = bytes_left - 2'd1;
                    if (bytes_left == 2'd0) close_sequence();
                end
            end
            if (lst) begin
                expected_verdicts.push_back(!failed);
                clear_string();
            end
        endfunction

        function void check_verdict(logic res);
            bit exp_res;
            if (expected_verdicts.size() == 0) begin
                $error("valid_res: unexpected verdict %0b with none pending", res);
                errors++;
                return;
            end
            exp_res = expected_verdicts.pop_front();
            n_verdicts++;
            if (exp_res) n_accepted++;
            if (res !== exp_res) begin
                $error("valid_res: expected %0b, actual %0b", exp_res, res);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_valid_res;

    verdict_tracker tracker;
    logic [7:0]     text_bytes[$];
    int             tx_calm;
    int             rx_calm;
    int             stall_run;
    int unsigned    cycle_count;

    utf8_stream_validator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit lst);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = lst;
        do @(posedge i_clk); while (o_stall);
        tracker.take_transfer(b, lst);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[k]) send_byte(text_bytes[k], k == text_bytes.size() - 1);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (tracker.expected_verdicts.size() != 0) @(negedge i_clk);
    endtask

    task automatic push_code(input logic [20:0] cp, input int len);
        case (len)
            1: text_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                text_bytes.push_back({3'b110, cp[10:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_bytes.push_back({4'b1110, cp[15:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_bytes.push_back({5'b11110, cp[20:18]});
                text_bytes.push_back({2'b10, cp[17:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_sequence();
        int          kind;
        int          len;
        int          start;
        logic [20:0] cp;
        kind  = $urandom_range(0, 15);
        start = text_bytes.size();
        len   = 1;
        case (kind)
            0, 1, 2, 3: cp = 21'($urandom_range(0, 'h7F));
            4, 5: begin
                len = 2;
                cp  = 21'($urandom_range('h80, 'h7FF));
            end
            6, 7: begin
                len = 3;
                cp  = 21'($urandom_range('h800, 'hFFFF));
            end
            8: begin
                len = 3;
                cp  = 21'($urandom_range('hD800, 'hDFFF));
            end
            9: begin
                len = $urandom_range(2, 3);
                cp  = 21'($urandom_range(0, 'h7FF));
            end
            10, 11: begin
                len = 4;
                cp  = 21'($urandom_range('h10000, 'h10FFFF));
            end
            12: begin
                len = 4;
                cp  = 21'($urandom_range(0, 1) ? $urandom_range('h110000, 'h13FFFF)
                                               : $urandom_range(0, 'hFFFF));
            end
            default: begin
                len = $urandom_range(2, 4);
                cp  = 21'($urandom_range('h80, 'h10FFFF));
            end
        endcase
        if (kind == 13) begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_code(cp, len);
        if (kind == 14) begin
            text_bytes[start + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end else if (kind == 15) begin
            repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
        end
    endtask

    initial begin
        i_stall   = 1'b0;
        stall_run = 0;
        rx_calm   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
                i_stall = 1'b1;
            end else begin
                i_stall   = 1'b0;
                stall_run = pick_gap(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_verdict(o_valid_res);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n_strings;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        tx_calm     = 0;
        cycle_count = 0;
        tracker     = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        text_bytes = '{8'h00, 8'h7F, 8'hDF, 8'hBF};       send_text();
        text_bytes = '{8'h80};                            send_text();
        text_bytes = '{8'hC1};                            send_text();
        text_bytes = '{8'hF5};                            send_text();
        text_bytes = '{8'hE0, 8'h80, 8'h80};              send_text();
        text_bytes = '{8'hED, 8'hA0, 8'h80};              send_text();
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};       send_text();
        text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};       send_text();
        text_bytes = '{8'hC2, 8'h41};                     send_text();
        text_bytes = '{8'hE2, 8'h41};                     send_text();
        text_bytes = '{8'hE2};                            send_text();
        text_bytes = '{8'hFF, 8'hC2};                     send_text();
        wait_drained();

        n_strings = 0;
        while (tracker.n_bytes < RANDOM_BYTES) begin
            text_bytes.delete();
            repeat (($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 12)) add_sequence();
            send_text();
            n_strings++;
            if (n_strings == 40) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.expected_verdicts.size() != 0) begin
            $error("valid_res: %0d verdicts never arrived", tracker.expected_verdicts.size());
            tracker.errors++;
        end
        $display("Covered %0d bytes in %0d strings: %0d judged valid, %0d rejected.",
                 tracker.n_bytes, tracker.n_verdicts, tracker.n_accepted,
                 tracker.n_verdicts - tracker.n_accepted);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
